// ===== hw/rtl/ccc_pkg.sv =====
// Shared constants and controller/datapath interface types for the component counter.
`timescale 1ns / 1ps

package ccc_pkg;

  // Table size and field widths
  localparam int MAX_NODES = 1024;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int COUNT_W   = 11;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;       // latch the incoming edge, start the walk at node_a
    logic rd_from_data;  // address the table with the word just read
    logic save_root_a;   // keep the first root, restart the walk at node_b
    logic hop;           // halve the path: point x at its grandparent, move to it
    logic link;          // hang the larger root under the smaller one
    logic emit;          // load the result, clear the merge count
    logic clear_step;    // write one table entry back to its own index
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic in_range;      // both incoming endpoints lie below node_count
    logic in_last;       // incoming item carries the last mark
    logic last;          // captured last mark of the current edge
    logic p_is_root;     // word just read equals its own address
    logic clear_last;    // clear sweep sits on the final entry
    logic out_busy;      // result register holds an item not yet taken
  } sts_t;

endpackage

// ===== hw/rtl/ccc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ccc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/ccc_datapath.sv =====
// Datapath: parent table, walk pointer, merge count, result register and clear sweep.
`timescale 1ns / 1ps

module ccc_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [ccc_pkg::COUNT_W-1:0]   cfg_wr_data,
  input  logic [ccc_pkg::NODE_W-1:0]    node_a,
  input  logic [ccc_pkg::NODE_W-1:0]    node_b,
  input  logic                          last_edge,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ccc_pkg::COUNT_W-1:0]   group_count,
  input  ccc_pkg::cmd_t                 cmd,
  output ccc_pkg::sts_t                 sts
);

  logic [ccc_pkg::COUNT_W-1:0] node_count;
  logic [ccc_pkg::COUNT_W-1:0] merge_count;
  logic [ccc_pkg::NODE_W-1:0]  x;
  logic [ccc_pkg::NODE_W-1:0]  root_a;
  logic [ccc_pkg::NODE_W-1:0]  end_b;
  logic                        last;
  logic [ccc_pkg::NODE_W-1:0]  clr_cnt;

  logic                        ram_we;
  logic [ccc_pkg::NODE_W-1:0]  ram_waddr;
  logic [ccc_pkg::NODE_W-1:0]  ram_wdata;
  logic [ccc_pkg::NODE_W-1:0]  ram_raddr;
  logic [ccc_pkg::NODE_W-1:0]  ram_rdata;

  logic                        roots_differ;
  logic [ccc_pkg::NODE_W-1:0]  root_hi;
  logic [ccc_pkg::NODE_W-1:0]  root_lo;

  // Node count register
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= ccc_pkg::COUNT_W'(ccc_pkg::MAX_NODES);
    end else if (cfg_wr_en) begin
      node_count <= cfg_wr_data;
    end
  end

  // Root comparison for the link step; the second root sits in x
  assign roots_differ = (root_a != x);
  assign root_hi      = (root_a > x) ? root_a : x;
  assign root_lo      = (root_a > x) ? x : root_a;

  // Table port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = x;
    ram_wdata = ram_rdata;
    if (cmd.clear_step) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt;
      ram_wdata = clr_cnt;
    end else if (cmd.hop) begin
      ram_we    = 1'b1;
      ram_waddr = x;
      ram_wdata = ram_rdata;
    end else if (cmd.link && roots_differ) begin
      ram_we    = 1'b1;
      ram_waddr = root_hi;
      ram_wdata = root_lo;
    end
  end

  assign ram_raddr = cmd.rd_from_data ? ram_rdata : x;

  ccc_ram #(
    .WIDTH (ccc_pkg::NODE_W),
    .DEPTH (ccc_pkg::MAX_NODES)
  ) u_parent (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Walk pointer and captured edge
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x     <= node_a;
      end_b <= node_b;
      last  <= last_edge;
    end else if (cmd.save_root_a) begin
      root_a <= x;
      x      <= end_b;
    end else if (cmd.hop) begin
      x <= ram_rdata;
    end
  end

  // Merge count: advance on a real link, drop on emit
  always_ff @(posedge clk) begin
    if (rst) begin
      merge_count <= '0;
    end else if (cmd.emit) begin
      merge_count <= '0;
    end else if (cmd.link && roots_differ) begin
      merge_count <= merge_count + 1'b1;
    end
  end

  // Clear sweep counter; emit restarts it
  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      clr_cnt <= '0;
    end else if (cmd.clear_step) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // Result register, saturating at zero
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      group_count <= (node_count > merge_count) ? (node_count - merge_count) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Status back to the controller
  always_comb begin
    sts.in_range   = ({1'b0, node_a} < node_count) && ({1'b0, node_b} < node_count);
    sts.in_last    = last_edge;
    sts.last       = last;
    sts.p_is_root  = (ram_rdata == x);
    sts.clear_last = (clr_cnt == ccc_pkg::NODE_W'(ccc_pkg::MAX_NODES - 1));
    sts.out_busy   = out_valid && out_stall;
  end

endmodule

// ===== hw/rtl/ccc_ctrl.sv =====
// Controller: sequences the clear sweep, the two root walks and link per edge, and the result after the last edge.
`timescale 1ns / 1ps

module ccc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  ccc_pkg::sts_t sts,
  output ccc_pkg::cmd_t cmd
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_PARENT = 3'd3;
  localparam logic [2:0] S_GRAND  = 3'd4;
  localparam logic [2:0] S_LINK   = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       phase;
  logic       phase_next;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      phase <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    phase_next = phase;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          phase_next  = 1'b0;
          if (sts.in_range) begin
            state_next = S_READ;
          end else if (sts.in_last) begin
            state_next = S_EMIT;
          end
        end
      end
      S_READ: begin
        state_next = S_PARENT;
      end
      S_PARENT: begin
        if (sts.p_is_root) begin
          if (!phase) begin
            cmd.save_root_a = 1'b1;
            phase_next      = 1'b1;
            state_next      = S_READ;
          end else begin
            state_next = S_LINK;
          end
        end else begin
          cmd.rd_from_data = 1'b1;
          state_next       = S_GRAND;
        end
      end
      S_GRAND: begin
        cmd.hop          = 1'b1;
        cmd.rd_from_data = 1'b1;
        state_next       = S_PARENT;
      end
      S_LINK: begin
        cmd.link   = 1'b1;
        state_next = sts.last ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (!sts.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_CLEAR;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/connected_component_counter.sv =====
// Top level of the connected component counter: controller plus datapath.
`timescale 1ns / 1ps

// Counts connected groups among node_count nodes, one undirected edge per item,
// using a 1024-entry union-find parent table with path halving. An in-range
// edge is captured; each of the two root walks then starts with a table read,
// every hop reads the parent and then the grandparent from the registered
// table read port, and a link step joins the two roots. An out-of-range edge
// is dropped. After the edge marked last the result is loaded into the output
// register and the table is swept back to identity, one entry a cycle; the
// same sweep runs after reset. No edge is taken during a sweep. The user must
// write node_count only while the block is idle; the block does not enforce it.
module connected_component_counter (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [ccc_pkg::COUNT_W-1:0] cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [ccc_pkg::NODE_W-1:0]  node_a,
  input  logic [ccc_pkg::NODE_W-1:0]  node_b,
  input  logic                        last_edge,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ccc_pkg::COUNT_W-1:0] group_count
);

  ccc_pkg::cmd_t cmd;
  ccc_pkg::sts_t sts;

  ccc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ccc_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .node_a      (node_a),
    .node_b      (node_b),
    .last_edge   (last_edge),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .group_count (group_count),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule
